// ----- hdl/pdd_pkg.sv -----
`default_nettype none
package pdd_pkg;

   localparam int unsigned NowWidth      = 32;
   localparam int unsigned DebounceWidth = 10;
   localparam int unsigned GapWidth      = 13;
   localparam int unsigned CountWidth    = 4;
   localparam int unsigned EventWidth    = 2;
   localparam int unsigned CsrIndexWidth = 1;
   localparam int unsigned CsrDataWidth  = GapWidth;

   localparam logic [CountWidth-1:0] DigitLast = CountWidth'(9);

   localparam logic [DebounceWidth-1:0] DebounceReset = DebounceWidth'(10);
   localparam logic [GapWidth-1:0]      GapReset      = GapWidth'(300);

   localparam logic [EventWidth-1:0] EV_NONE  = 2'd0;
   localparam logic [EventWidth-1:0] EV_MAYBE = 2'd1;
   localparam logic [EventWidth-1:0] EV_START = 2'd2;
   localparam logic [EventWidth-1:0] EV_DIGIT = 2'd3;

   localparam logic KIND_SAMPLE  = 1'b0;
   localparam logic KIND_RESTART = 1'b1;

   localparam logic [CsrIndexWidth-1:0] CSR_DEBOUNCE = 1'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_GAP      = 1'd1;

   typedef struct packed {
      logic                kind;
      logic                hook_level;
      logic [NowWidth-1:0] now_ms;
   } req_word_type;

   typedef struct packed {
      logic [EventWidth-1:0] event_code;
      logic [CountWidth-1:0] digit;
   } rsp_word_type;

   typedef struct packed {
      logic [DebounceWidth-1:0] debounce_min_ms;
      logic [GapWidth-1:0]      digit_gap_ms;
   } cfg_type;

endpackage
`default_nettype wire

// ----- hdl/pdd_in_reg.sv -----
`default_nettype none
module pdd_in_reg (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire pdd_pkg::req_word_type req_word,
   input  wire logic                  advance,
   output logic                       held_valid,
   output pdd_pkg::req_word_type      held_word
);

   logic                  valid_ff;
   logic                  valid_in;
   pdd_pkg::req_word_type word_ff;

   assign req_ready  = !valid_ff || advance;
   assign valid_in   = (req_valid && req_ready) || (valid_ff && !advance);
   assign held_valid = valid_ff;
   assign held_word  = word_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // load a new word whenever the slot frees
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         word_ff <= req_word;
      end
   end

endmodule
`default_nettype wire

// ----- hdl/pdd_core.sv -----
`default_nettype none
module pdd_core (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  advance,
   input  wire pdd_pkg::req_word_type word,
   input  wire pdd_pkg::cfg_type      cfg,
   output pdd_pkg::rsp_word_type      result
);

   logic                              accepted_ff, accepted_in;
   logic                              last_raw_ff, last_raw_in;
   logic [pdd_pkg::NowWidth-1:0]      debounce_stamp_ff, debounce_stamp_in;
   logic [pdd_pkg::NowWidth-1:0]      edge_stamp_ff, edge_stamp_in;
   logic                              armed_ff, armed_in;
   logic                              dialing_ff, dialing_in;
   logic                              pulse_ff, pulse_in;
   logic [pdd_pkg::CountWidth-1:0]    count_ff, count_in;
   logic [pdd_pkg::NowWidth-1:0]      held_time;
   logic [pdd_pkg::NowWidth-1:0]      gap;
   logic                              unstable;
   logic                              gap_over;
   logic                              lvl;

   assign lvl       = word.hook_level;
   assign held_time = word.now_ms - debounce_stamp_ff;
   assign unstable  = held_time < pdd_pkg::NowWidth'(cfg.debounce_min_ms);
   assign gap       = (edge_stamp_ff != '0) ? (word.now_ms - edge_stamp_ff) : '0;
   assign gap_over  = gap > pdd_pkg::NowWidth'(cfg.digit_gap_ms);

   always_comb begin
      accepted_in       = accepted_ff;
      last_raw_in       = last_raw_ff;
      debounce_stamp_in = debounce_stamp_ff;
      edge_stamp_in     = edge_stamp_ff;
      armed_in          = armed_ff;
      dialing_in        = dialing_ff;
      pulse_in          = pulse_ff;
      count_in          = count_ff;
      result.event_code = pdd_pkg::EV_NONE;
      result.digit      = '0;
      if (word.kind == pdd_pkg::KIND_RESTART) begin
         armed_in          = 1'b0;
         dialing_in        = 1'b0;
         pulse_in          = 1'b0;
         count_in          = '0;
         edge_stamp_in     = '0;
         debounce_stamp_in = word.now_ms;
      end else if (lvl != last_raw_ff) begin
         last_raw_in       = lvl;
         debounce_stamp_in = word.now_ms;
         if (!lvl && !armed_ff) begin
            armed_in          = 1'b1;
            result.event_code = pdd_pkg::EV_MAYBE;
         end
      end else if (unstable) begin
         accepted_in = accepted_ff;
      end else if (lvl && accepted_ff && !gap_over) begin
         accepted_in = accepted_ff;
      end else if (!lvl && !accepted_ff) begin
         accepted_in = accepted_ff;
      end else begin
         accepted_in = lvl;
         if (!lvl && !pulse_ff) begin
            pulse_in      = 1'b1;
            edge_stamp_in = word.now_ms;
         end else if (lvl && pulse_ff) begin
            pulse_in      = 1'b0;
            count_in      = (count_ff == pdd_pkg::DigitLast) ? '0 : count_ff + 1'b1;
            edge_stamp_in = word.now_ms;
            if (!dialing_ff) begin
               dialing_in        = 1'b1;
               result.event_code = pdd_pkg::EV_START;
            end
         end else if (lvl && !pulse_ff && gap_over) begin
            result.event_code = pdd_pkg::EV_DIGIT;
            result.digit      = count_ff;
            count_in          = '0;
            edge_stamp_in     = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         accepted_ff       <= 1'b1;
         last_raw_ff       <= 1'b1;
         debounce_stamp_ff <= '0;
         edge_stamp_ff     <= '0;
         armed_ff          <= 1'b0;
         dialing_ff        <= 1'b0;
         pulse_ff          <= 1'b0;
         count_ff          <= '0;
      end else if (advance) begin
         accepted_ff       <= accepted_in;
         last_raw_ff       <= last_raw_in;
         debounce_stamp_ff <= debounce_stamp_in;
         edge_stamp_ff     <= edge_stamp_in;
         armed_ff          <= armed_in;
         dialing_ff        <= dialing_in;
         pulse_ff          <= pulse_in;
         count_ff          <= count_in;
      end
   end

endmodule
`default_nettype wire

// ----- hdl/pdd_out_reg.sv -----
`default_nettype none
module pdd_out_reg (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  load_valid,
   output logic                       load_ready,
   input  wire pdd_pkg::rsp_word_type load_word,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output pdd_pkg::rsp_word_type      rsp_word
);

   logic                  valid_ff;
   logic                  valid_in;
   pdd_pkg::rsp_word_type word_ff;

   assign load_ready = !valid_ff || rsp_ready;
   assign valid_in   = (load_valid && load_ready) || (valid_ff && !rsp_ready);
   assign rsp_valid  = valid_ff;
   assign rsp_word   = word_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_valid && load_ready) begin
         word_ff <= load_word;
      end
   end

endmodule
`default_nettype wire

// ----- hdl/pulse_dial_digit_decoder.sv -----
// A word accepted on req passes the input register, then the result register, on its way to rsp.
// Throughput: one word per cycle unless rsp stalls; a single decode pass between the two registers.
// Backpressure on rsp reaches req_ready in the same cycle.
// Reset: synchronous, active high; clears both stages, the decoder state and the two
// settings to their defaults (debounce 10 ms, digit gap 300 ms).
`default_nettype none
module pulse_dial_digit_decoder (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire pdd_pkg::req_word_type               req_word,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output pdd_pkg::rsp_word_type                    rsp_word,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [pdd_pkg::CsrIndexWidth-1:0]   csr_index,
   input  wire logic [pdd_pkg::CsrDataWidth-1:0]    csr_data
);

   pdd_pkg::cfg_type      cfg_ff;
   pdd_pkg::req_word_type held_word;
   pdd_pkg::rsp_word_type result;
   logic                  held_valid;
   logic                  load_ready;
   logic                  advance;

   assign csr_ready = 1'b1;
   assign advance   = held_valid && load_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_min_ms <= pdd_pkg::DebounceReset;
         cfg_ff.digit_gap_ms    <= pdd_pkg::GapReset;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            pdd_pkg::CSR_DEBOUNCE: begin
               cfg_ff.debounce_min_ms <= csr_data[pdd_pkg::DebounceWidth-1:0];
            end
            pdd_pkg::CSR_GAP: begin
               cfg_ff.digit_gap_ms <= csr_data;
            end
            default: begin
               cfg_ff <= cfg_ff;
            end
         endcase
      end
   end

   pdd_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_word   (req_word),
      .advance    (advance),
      .held_valid (held_valid),
      .held_word  (held_word)
   );

   pdd_core u_core (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .word    (held_word),
      .cfg     (cfg_ff),
      .result  (result)
   );

   pdd_out_reg u_out_reg (
      .clock      (clock),
      .reset      (reset),
      .load_valid (held_valid),
      .load_ready (load_ready),
      .load_word  (result),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_word   (rsp_word)
   );

endmodule
`default_nettype wire

// ----- hdl/pdd_checker.sv -----
`default_nettype none
module pdd_checker (
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  req_valid,
   input wire logic                  req_ready,
   input wire logic                  rsp_valid,
   input wire logic                  rsp_ready,
   input wire pdd_pkg::rsp_word_type rsp_word
);

   // hold a stalled result word
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_word))
      else $error("rsp word changed while stalled");

   // drop the digit unless a digit is reported
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.event_code != pdd_pkg::EV_DIGIT |-> rsp_word.digit == '0)
      else $error("digit set without digit event");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.event_code == pdd_pkg::EV_DIGIT |-> rsp_word.digit <= 4'd9)
      else $error("digit out of range");

   assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_valid)
      else $error("rsp valid right after reset");

   // a free output slot never blocks the input
   assert property (@(posedge clock) disable iff (reset)
      !rsp_valid && $past(!req_valid) && !$past(reset) |-> req_ready)
      else $error("req stalled with an empty pipeline");

endmodule

bind pulse_dial_digit_decoder pdd_checker u_pdd_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_word  (rsp_word)
);
`default_nettype wire
